// File: rtl/core/c8ie_pkg.sv
// ----------------------------------------------------------------------------
// c8ie_pkg
// Shared constants, instruction families and the result layout for the
// instruction execute block.
// ----------------------------------------------------------------------------
package c8ie_pkg;

    localparam int STACK_ENTRIES = 16;
    localparam int REG_COUNT     = 16;
    localparam int ADDR_BITS     = 12;

    localparam int REG_W   = $clog2(REG_COUNT);
    localparam int DEPTH_W = $clog2(STACK_ENTRIES + 1);

    localparam int IN_W  = 24;
    localparam int OUT_W = 48;

    localparam logic [ADDR_BITS-1:0] PC_RESET = ADDR_BITS'(12'h200);

    typedef enum logic [3:0] {
        FAM_JP    = 4'h1,
        FAM_CALL  = 4'h2,
        FAM_SEI   = 4'h3,
        FAM_SNEI  = 4'h4,
        FAM_SER   = 4'h5,
        FAM_LDI   = 4'h6,
        FAM_ADDI  = 4'h7,
        FAM_SNER  = 4'h9,
        FAM_LDIDX = 4'hA,
        FAM_JPV0  = 4'hB,
        FAM_RND   = 4'hC
    } t_family;

    typedef struct packed {
        logic [2:0]  pad;
        logic        unimplemented;
        logic        stack_overflow;
        logic [4:0]  call_depth;
        logic        skip_taken;
        logic [7:0]  reg_data;
        logic [3:0]  reg_number;
        logic        reg_written;
        logic [11:0] index_value;
        logic [11:0] next_pc;
    } t_result;

endpackage

// File: rtl/core/c8ie_ram.sv
// ----------------------------------------------------------------------------
// c8ie_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module c8ie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// File: rtl/core/chip8_instruction_execute_top.sv
// ----------------------------------------------------------------------------
// chip8_instruction_execute_top
// Executes one fetched instruction word per request and reports the new
// program counter, index register, register write, skip and stack status.
// ----------------------------------------------------------------------------
// usage
//   s_axis: one request per instruction, tdata = {random_byte, instr_word}
//   m_axis: one result per request, in order, fields listed at the port
//   a request accepted on s_axis is held in the execute stage; its result is
//   registered when the execute step fires and stays on m_axis until taken
//   one request per cycle is sustained while m_axis_tready is high; the register
//   file read is issued as the request is taken and the execute step uses its data
//   writes of the previous instruction are forwarded, so back to back
//   dependent instructions run without a bubble
//   when m_axis_tready is low the result is held, the execute stage holds
//   one request and s_axis_tready drops once both are full
//   reset: pc = 0x200, registers and index cleared, call depth zero
//   return addresses are not kept since no instruction reads them back
// ----------------------------------------------------------------------------
module chip8_instruction_execute_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // [15:0] instr_word, [23:16] random_byte
    input  logic [c8ie_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // [11:0] next_pc, [23:12] index_value, [24] reg_written,
    // [28:25] reg_number, [36:29] reg_data, [37] skip_taken,
    // [42:38] call_depth, [43] stack_overflow, [44] unimplemented, [47:45] zero
    output logic [c8ie_pkg::OUT_W-1:0] m_axis_tdata
);

    import c8ie_pkg::*;

    logic                 s_fire;
    logic                 x_fire;
    logic                 r_in_valid;
    logic [15:0]          r_word;
    logic [7:0]           r_rnd;
    logic                 r_out_valid;
    t_result              r_out;
    t_result              n_out;

    logic [ADDR_BITS-1:0] r_pc;
    logic [ADDR_BITS-1:0] n_pc;
    logic [ADDR_BITS-1:0] r_index;
    logic [ADDR_BITS-1:0] n_index;
    logic [DEPTH_W-1:0]   r_depth;
    logic [DEPTH_W-1:0]   n_depth;
    logic [REG_COUNT-1:0] r_reg_vld;
    logic [7:0]           r_v0;

    logic                 r_fwd_x;
    logic                 r_fwd_y;
    logic [7:0]           r_fwd_data;
    logic [7:0]           rdata_a;
    logic [7:0]           rdata_b;

    logic [REG_W-1:0]     x;
    logic [REG_W-1:0]     y;
    logic [7:0]           imm8;
    logic [11:0]          addr;
    logic [7:0]           vx;
    logic [7:0]           vy;
    logic [ADDR_BITS-1:0] pc_inc;
    logic                 wr;
    logic [7:0]           wdata;
    logic                 skip;
    logic                 ovf;
    logic                 unimpl;
    logic                 reg_we;

    assign x_fire        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || x_fire;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign x    = r_word[11:8];
    assign y    = r_word[7:4];
    assign imm8 = r_word[7:0];
    assign addr = r_word[11:0];

    assign reg_we = x_fire && wr;

    c8ie_ram #(
        .WIDTH (8),
        .DEPTH (REG_COUNT)
    ) u_regs (
        .i_clk     (i_clk),
        .i_we      (reg_we),
        .i_waddr   (x),
        .i_wdata   (wdata),
        .i_re      (s_fire),
        .i_raddr_a (s_axis_tdata[11:8]),
        .i_raddr_b (s_axis_tdata[7:4]),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    always_comb begin
        vx = r_reg_vld[x] ? rdata_a : 8'h00;
        vy = r_reg_vld[y] ? rdata_b : 8'h00;
        if (r_fwd_x) begin
            vx = r_fwd_data;
        end
        if (r_fwd_y) begin
            vy = r_fwd_data;
        end
    end

    always_comb begin
        pc_inc  = r_pc + ADDR_BITS'(2);
        n_pc    = pc_inc;
        n_index = r_index;
        n_depth = r_depth;
        wr      = 1'b0;
        wdata   = 8'h00;
        skip    = 1'b0;
        ovf     = 1'b0;
        unimpl  = 1'b0;
        case (r_word[15:12])
            FAM_JP: begin
                n_pc = ADDR_BITS'(addr);
            end
            FAM_CALL: begin
                if (r_depth < DEPTH_W'(STACK_ENTRIES)) begin
                    n_depth = r_depth + DEPTH_W'(1);
                end else begin
                    ovf = 1'b1;
                end
                n_pc = ADDR_BITS'(addr);
            end
            FAM_SEI:   skip = (vx == imm8);
            FAM_SNEI:  skip = (vx != imm8);
            FAM_SER:   skip = (vx == vy);
            FAM_SNER:  skip = (vx != vy);
            FAM_LDI: begin
                wr    = 1'b1;
                wdata = imm8;
            end
            FAM_ADDI: begin
                wr    = 1'b1;
                wdata = vx + imm8;
            end
            FAM_LDIDX: begin
                n_index = ADDR_BITS'(addr);
            end
            FAM_JPV0: begin
                n_pc = ADDR_BITS'(addr) + ADDR_BITS'(r_v0);
            end
            FAM_RND: begin
                wr    = 1'b1;
                wdata = r_rnd & imm8;
            end
            default: unimpl = 1'b1;
        endcase
        if (skip) begin
            n_pc = pc_inc + ADDR_BITS'(2);
        end
    end

    always_comb begin
        n_out                = '0;
        n_out.next_pc        = n_pc[11:0];
        n_out.index_value    = n_index[11:0];
        n_out.reg_written    = wr;
        n_out.reg_number     = wr ? x : 4'h0;
        n_out.reg_data       = wdata;
        n_out.skip_taken     = skip;
        n_out.call_depth     = 5'(n_depth);
        n_out.stack_overflow = ovf;
        n_out.unimplemented  = unimpl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pc        <= PC_RESET;
            r_index     <= '0;
            r_depth     <= '0;
            r_reg_vld   <= '0;
            r_v0        <= 8'h00;
            r_fwd_x     <= 1'b0;
            r_fwd_y     <= 1'b0;
        end else begin
            if (s_fire) begin
                r_in_valid <= 1'b1;
                r_fwd_x    <= reg_we && (x == s_axis_tdata[11:8]);
                r_fwd_y    <= reg_we && (x == s_axis_tdata[7:4]);
            end else if (x_fire) begin
                r_in_valid <= 1'b0;
            end
            if (x_fire) begin
                r_out_valid <= 1'b1;
                r_pc        <= n_pc;
                r_index     <= n_index;
                r_depth     <= n_depth;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (reg_we) begin
                r_reg_vld[x] <= 1'b1;
                if (x == '0) begin
                    r_v0 <= wdata;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_word     <= s_axis_tdata[15:0];
            r_rnd      <= s_axis_tdata[23:16];
            r_fwd_data <= wdata;
        end
        if (x_fire) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // call depth never passes the stack size
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_W'(STACK_ENTRIES))
        else $error("call depth above stack size");

    // an overflowing call leaves the stack full
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        x_fire && ovf |=> r_depth == DEPTH_W'(STACK_ENTRIES))
        else $error("overflow with stack not full");

    // a write to register zero updates the jump base
    a_v0_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        reg_we && (x == '0) |=> r_v0 == $past(wdata))
        else $error("v0 copy out of step");

    // an unimplemented family never writes a register
    a_unimpl_nowr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(r_out.unimplemented && r_out.reg_written))
        else $error("unimplemented instruction wrote a register");

endmodule
